FILE: design/slex_pkg.sv
package slex_pkg;

	localparam int POSITION_BITS = 16;
	localparam int KEYWORD_CHARS = 6;
	localparam int WLEN_BITS = $clog2(KEYWORD_CHARS + 2);
	localparam int OUT_BITS = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [OUT_BITS-1:0] LINE_MAX = '1;

	typedef enum logic [3:0] {
		MODE_IDLE = 4'd0,
		MODE_OP_EQ = 4'd1,
		MODE_OP_PLUS = 4'd2,
		MODE_OP_MINUS = 4'd3,
		MODE_OP_STAR = 4'd4,
		MODE_OP_SLASH = 4'd5,
		MODE_OP_PCT = 4'd6,
		MODE_OP_GT = 4'd7,
		MODE_OP_LT = 4'd8,
		MODE_INT = 4'd9,
		MODE_DOT = 4'd10,
		MODE_FRAC = 4'd11,
		MODE_STR = 4'd12,
		MODE_WORD = 4'd13
	} mode_t;

	localparam logic [5:0] KIND_EOF = 6'd0;
	localparam logic [5:0] KIND_PUNCT0 = 6'd1;
	localparam logic [5:0] KIND_INT = 6'd27;
	localparam logic [5:0] KIND_FLOAT = 6'd28;
	localparam logic [5:0] KIND_STRING = 6'd29;
	localparam logic [5:0] KIND_IDENT = 6'd30;
	localparam logic [5:0] KIND_KEYWORD0 = 6'd31;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_STRING = 2'd1;
	localparam logic [1:0] ERR_DOT = 2'd2;
	localparam logic [1:0] ERR_BYTE = 2'd3;

	localparam logic [7:0] CH_NL = 8'h0a;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_EQ = 8'h3d;
	localparam logic [7:0] CH_DOT = 8'h2e;

	typedef struct packed {
		logic [5:0] kind;
		logic [POSITION_BITS-1:0] start;
		logic [POSITION_BITS-1:0] stop;
		logic [OUT_BITS-1:0] line;
		logic [1:0] err;
	} tok_t;

	typedef struct packed {
		logic [1:0] count;
		tok_t t0;
		tok_t t1;
		tok_t t2;
	} batch_t;

	function automatic logic [7:0] op_char(input logic [2:0] i);
		case (i)
			3'd0: op_char = 8'h3d;
			3'd1: op_char = 8'h2b;
			3'd2: op_char = 8'h2d;
			3'd3: op_char = 8'h2a;
			3'd4: op_char = 8'h2f;
			3'd5: op_char = 8'h25;
			3'd6: op_char = 8'h3e;
			default: op_char = 8'h3c;
		endcase
	endfunction

	function automatic logic [5:0] op_single(input logic [2:0] i);
		case (i)
			3'd0: op_single = 6'd9;
			3'd1: op_single = 6'd11;
			3'd2: op_single = 6'd14;
			3'd3: op_single = 6'd17;
			3'd4: op_single = 6'd19;
			3'd5: op_single = 6'd21;
			3'd6: op_single = 6'd23;
			default: op_single = 6'd25;
		endcase
	endfunction

	function automatic logic [5:0] op_double(input logic [2:0] i);
		case (i)
			3'd1: op_double = 6'd13;
			3'd2: op_double = 6'd16;
			default: op_double = KIND_EOF;
		endcase
	endfunction

	function automatic logic [7:0] punct_char(input logic [2:0] i);
		case (i)
			3'd0: punct_char = 8'h3b;
			3'd1: punct_char = 8'h7b;
			3'd2: punct_char = 8'h7d;
			3'd3: punct_char = 8'h5b;
			3'd4: punct_char = 8'h5d;
			3'd5: punct_char = 8'h28;
			3'd6: punct_char = 8'h29;
			default: punct_char = 8'h2e;
		endcase
	endfunction

	function automatic logic [8*KEYWORD_CHARS-1:0] kw_text(input logic [3:0] k);
		case (k)
			4'd0: kw_text = 48'h65_74_79_62;
			4'd1: kw_text = 48'h74_72_6f_68_73;
			4'd2: kw_text = 48'h74_6e_69;
			4'd3: kw_text = 48'h67_6e_6f_6c;
			4'd4: kw_text = 48'h74_61_6f_6c_66;
			4'd5: kw_text = 48'h6c_6f_6f_62;
			4'd6: kw_text = 48'h6f_64;
			4'd7: kw_text = 48'h65_6c_69_68_77;
			4'd8: kw_text = 48'h72_6f_66;
			4'd9: kw_text = 48'h66_69;
			4'd10: kw_text = 48'h65_73_6c_65;
			4'd11: kw_text = 48'h66_69_65_73_6c_65;
			4'd12: kw_text = 48'h65_75_72_74;
			default: kw_text = 48'h65_73_6c_61_66;
		endcase
	endfunction

	function automatic logic [WLEN_BITS-1:0] kw_len(input logic [3:0] k);
		case (k)
			4'd0, 4'd3, 4'd5, 4'd10, 4'd12: kw_len = WLEN_BITS'(4);
			4'd1, 4'd4, 4'd7, 4'd13: kw_len = WLEN_BITS'(5);
			4'd2, 4'd8: kw_len = WLEN_BITS'(3);
			4'd6, 4'd9: kw_len = WLEN_BITS'(2);
			default: kw_len = WLEN_BITS'(6);
		endcase
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		digit_char = (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic letter_char(input logic [7:0] c);
		letter_char = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
			|| (c == 8'h5f);
	endfunction

	function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] p);
		sat_inc = (p == POS_MAX) ? p : p + 1'b1;
	endfunction

endpackage

FILE: design/source_lexer.sv
// source_lexer: streaming tokenizer
// input channel: in_valid/in_stall with source_byte and final_byte, one byte per item
// output channel: out_valid/out_stall with one token per item
// each byte yields zero to three tokens; run_last marks the last token of a byte
// the front part scans one byte per cycle while the queue is not full and pushes the
// byte's tokens as one entry into a four-entry queue; the back part sends one token per
// cycle while out_stall is low; tokens pass the queue, then the output registers
// throughput: one byte per cycle while bytes yield at most one token each and
// out_stall is low; a byte's tokens are sent in order before the next entry is taken
// in_stall rises only when the queue is full
// after final_byte the position, line and mode return to their reset values
// reset clears the scanner state and out_valid and empties the queue
// when out_stall is high the current token holds and the queue fills
module source_lexer
	import slex_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] source_byte,
	input logic final_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [5:0] token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [15:0] token_line,
	output logic [1:0] scan_error,
	output logic run_last
);

	batch_t fb, qb;
	logic fb_valid, full, empty, take;

	assign in_stall = full;

	slex_front u_front (
		.clk, .arst_n,
		.in_valid(in_valid && !full),
		.in_byte(source_byte),
		.in_final(final_byte),
		.batch(fb),
		.batch_valid(fb_valid)
	);

	slex_queue u_queue (
		.clk, .arst_n,
		.wr_en(fb_valid),
		.wr_data(fb),
		.full,
		.rd_en(take),
		.rd_data(qb),
		.empty
	);

	slex_back u_back (
		.clk, .arst_n,
		.batch(qb),
		.batch_ready(!empty),
		.batch_take(take),
		.out_valid, .out_stall,
		.token_kind, .token_start, .token_length, .token_line, .scan_error, .run_last
	);

endmodule

FILE: design/slex_front.sv
module slex_front
	import slex_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] in_byte,
	input logic in_final,
	output batch_t batch,
	output logic batch_valid
);

	logic [POSITION_BITS-1:0] pos_q, start_q;
	logic [OUT_BITS-1:0] line_q;
	mode_t mode_q;
	logic [8*KEYWORD_CHARS-1:0] prefix_q;
	logic [WLEN_BITS-1:0] wlen_q;

	logic [POSITION_BITS-1:0] start_d;
	logic [OUT_BITS-1:0] line_d;
	mode_t mode_d;
	logic [8*KEYWORD_CHARS-1:0] prefix_d;
	logic [WLEN_BITS-1:0] wlen_d;
	tok_t toks [3];
	logic [1:0] n;
	logic consumed;
	logic [POSITION_BITS-1:0] end_pos;
	logic [5:0] wkind;
	logic [2:0] opi;

	// keyword lookup on the word held so far
	always_comb begin
		wkind = KIND_IDENT;
		for (int k = 13; k >= 0; k--) begin
			if (wlen_q == kw_len(4'(k)) && prefix_q == kw_text(4'(k)))
				wkind = KIND_KEYWORD0 + 6'(k);
		end
	end

	always_comb begin
		start_d = start_q;
		line_d = line_q;
		mode_d = mode_q;
		prefix_d = prefix_q;
		wlen_d = wlen_q;
		n = 2'd0;
		consumed = 1'b0;
		end_pos = sat_inc(pos_q);
		opi = 3'(mode_q - 4'd1);
		for (int i = 0; i < 3; i++) toks[i] = '0;

		case (mode_q)
			MODE_OP_EQ, MODE_OP_PLUS, MODE_OP_MINUS, MODE_OP_STAR, MODE_OP_SLASH,
			MODE_OP_PCT, MODE_OP_GT, MODE_OP_LT: begin
				if (in_byte == CH_EQ) begin
					toks[0] = '{kind: op_single(opi) + 6'd1, start: start_q, stop: end_pos,
						line: line_q, err: ERR_NONE};
					n = 2'd1;
					mode_d = MODE_IDLE;
					consumed = 1'b1;
				end else if (op_double(opi) != KIND_EOF && in_byte == op_char(opi)) begin
					toks[0] = '{kind: op_double(opi), start: start_q, stop: end_pos,
						line: line_q, err: ERR_NONE};
					n = 2'd1;
					mode_d = MODE_IDLE;
					consumed = 1'b1;
				end else begin
					toks[0] = '{kind: op_single(opi), start: start_q, stop: pos_q,
						line: line_q, err: ERR_NONE};
					n = 2'd1;
					mode_d = MODE_IDLE;
				end
			end
			MODE_INT: begin
				if (digit_char(in_byte)) consumed = 1'b1;
				else if (in_byte == CH_DOT) begin
					mode_d = MODE_DOT;
					consumed = 1'b1;
				end else begin
					toks[0] = '{kind: KIND_INT, start: start_q, stop: pos_q, line: line_q,
						err: ERR_NONE};
					n = 2'd1;
					mode_d = MODE_IDLE;
				end
			end
			MODE_DOT, MODE_FRAC: begin
				if (digit_char(in_byte)) begin
					mode_d = MODE_FRAC;
					consumed = 1'b1;
				end else begin
					toks[0] = '{kind: KIND_FLOAT, start: start_q, stop: pos_q, line: line_q,
						err: (mode_q == MODE_DOT) ? ERR_DOT : ERR_NONE};
					n = 2'd1;
					mode_d = MODE_IDLE;
				end
			end
			MODE_STR: begin
				consumed = 1'b1;
				if (in_byte == CH_QUOTE) begin
					toks[0] = '{kind: KIND_STRING, start: start_q, stop: end_pos,
						line: line_q, err: ERR_NONE};
					n = 2'd1;
					mode_d = MODE_IDLE;
				end
			end
			MODE_WORD: begin
				if (letter_char(in_byte)) begin
					consumed = 1'b1;
					if (wlen_q < WLEN_BITS'(KEYWORD_CHARS)) begin
						prefix_d = prefix_q | ((8*KEYWORD_CHARS)'(in_byte) << (8 * wlen_q));
						wlen_d = wlen_q + 1'b1;
					end else wlen_d = WLEN_BITS'(KEYWORD_CHARS + 1);
				end else begin
					toks[0] = '{kind: wkind, start: start_q, stop: pos_q, line: line_q,
						err: ERR_NONE};
					n = 2'd1;
					mode_d = MODE_IDLE;
				end
			end
			default: mode_d = MODE_IDLE;
		endcase

		if (!consumed) begin
			if (in_byte == 8'h20 || in_byte == 8'h0d || in_byte == 8'h09) begin
			end else if (in_byte == CH_NL) begin
				if (line_q != LINE_MAX) line_d = line_q + 1'b1;
			end else begin
				start_d = pos_q;
				if (in_byte == punct_char(3'd0) || in_byte == punct_char(3'd1)
					|| in_byte == punct_char(3'd2) || in_byte == punct_char(3'd3)
					|| in_byte == punct_char(3'd4) || in_byte == punct_char(3'd5)
					|| in_byte == punct_char(3'd6) || in_byte == punct_char(3'd7)) begin
					toks[n] = '{kind: KIND_EOF, start: pos_q, stop: end_pos, line: line_q,
						err: ERR_NONE};
					for (int i = 0; i < 8; i++)
						if (in_byte == punct_char(3'(i))) toks[n].kind = KIND_PUNCT0 + 6'(i);
					n = n + 2'd1;
				end else begin
					toks[n] = '{kind: KIND_EOF, start: pos_q, stop: end_pos, line: line_q,
						err: ERR_BYTE};
					for (int i = 0; i < 8; i++)
						if (in_byte == op_char(3'(i))) mode_d = mode_t'(4'(i + 1));
					if (in_byte == CH_QUOTE) mode_d = MODE_STR;
					else if (digit_char(in_byte)) mode_d = MODE_INT;
					else if (letter_char(in_byte)) begin
						mode_d = MODE_WORD;
						prefix_d = (8*KEYWORD_CHARS)'(in_byte);
						wlen_d = WLEN_BITS'(1);
					end
					if (mode_d == MODE_IDLE) n = n + 2'd1;
				end
			end
		end

		if (in_final) begin
			case (mode_d)
				MODE_OP_EQ, MODE_OP_PLUS, MODE_OP_MINUS, MODE_OP_STAR, MODE_OP_SLASH,
				MODE_OP_PCT, MODE_OP_GT, MODE_OP_LT: begin
					toks[n] = '{kind: op_single(3'(mode_d - 4'd1)), start: start_d,
						stop: end_pos, line: line_d, err: ERR_NONE};
					n = n + 2'd1;
				end
				MODE_INT: begin
					toks[n] = '{kind: KIND_INT, start: start_d, stop: end_pos, line: line_d,
						err: ERR_NONE};
					n = n + 2'd1;
				end
				MODE_DOT, MODE_FRAC: begin
					toks[n] = '{kind: KIND_FLOAT, start: start_d, stop: end_pos,
						line: line_d, err: (mode_d == MODE_DOT) ? ERR_DOT : ERR_NONE};
					n = n + 2'd1;
				end
				MODE_STR: begin
					toks[n] = '{kind: KIND_STRING, start: start_d, stop: end_pos,
						line: line_d, err: ERR_STRING};
					n = n + 2'd1;
				end
				MODE_WORD: begin
					// word kind after the final letter was added
					toks[n] = '{kind: KIND_IDENT, start: start_d, stop: end_pos,
						line: line_d, err: ERR_NONE};
					for (int k = 13; k >= 0; k--)
						if (wlen_d == kw_len(4'(k)) && prefix_d == kw_text(4'(k)))
							toks[n].kind = KIND_KEYWORD0 + 6'(k);
					n = n + 2'd1;
				end
				default: ;
			endcase
			toks[n] = '{kind: KIND_EOF, start: end_pos, stop: end_pos, line: line_d,
				err: ERR_NONE};
			n = n + 2'd1;
		end
	end

	assign batch.count = n;
	assign batch.t0 = toks[0];
	assign batch.t1 = toks[1];
	assign batch.t2 = toks[2];
	assign batch_valid = in_valid && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			start_q <= '0;
			line_q <= '0;
			mode_q <= MODE_IDLE;
			prefix_q <= '0;
			wlen_q <= '0;
		end else if (in_valid) begin
			if (in_final) begin
				pos_q <= '0;
				start_q <= '0;
				line_q <= '0;
				mode_q <= MODE_IDLE;
				prefix_q <= '0;
				wlen_q <= '0;
			end else begin
				pos_q <= end_pos;
				start_q <= start_d;
				line_q <= line_d;
				mode_q <= mode_d;
				prefix_q <= prefix_d;
				wlen_q <= wlen_d;
			end
		end
	end

endmodule

FILE: design/slex_queue.sv
module slex_queue
	import slex_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input batch_t wr_data,
	output logic full,
	input logic rd_en,
	output batch_t rd_data,
	output logic empty
);

	batch_t mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS:0] wp_q, rp_q;

	assign empty = (wp_q == rp_q);
	assign full = (wp_q[QPTR_BITS] != rp_q[QPTR_BITS])
		&& (wp_q[QPTR_BITS-1:0] == rp_q[QPTR_BITS-1:0]);
	assign rd_data = mem_q[rp_q[QPTR_BITS-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q[QPTR_BITS-1:0]] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
		end
	end

endmodule

FILE: design/slex_back.sv
module slex_back
	import slex_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input batch_t batch,
	input logic batch_ready,
	output logic batch_take,
	output logic out_valid,
	input logic out_stall,
	output logic [5:0] token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [15:0] token_line,
	output logic [1:0] scan_error,
	output logic run_last
);

	logic [1:0] idx_q;
	tok_t cur;
	logic last;
	logic load;
	logic [POSITION_BITS-1:0] len;

	always_comb begin
		case (idx_q)
			2'd0: cur = batch.t0;
			2'd1: cur = batch.t1;
			default: cur = batch.t2;
		endcase
	end

	assign last = (idx_q + 2'd1 == batch.count);
	assign load = batch_ready && (!out_valid || !out_stall);
	assign batch_take = load && last;
	assign len = (cur.stop >= cur.start) ? cur.stop - cur.start : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			token_kind <= cur.kind;
			token_start <= 16'(cur.start);
			token_length <= 16'(len);
			token_line <= cur.line;
			scan_error <= cur.err;
			run_last <= last;
		end
	end

endmodule

FILE: design/slex_checker.sv
module slex_checker
	import slex_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [5:0] token_kind,
	input logic [15:0] token_length,
	input logic [1:0] scan_error,
	input logic run_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(run_last))
		else $error("stalled token changed");

	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_EOF && scan_error == ERR_NONE |-> token_length == 16'd0
			&& run_last)
		else $error("eof token malformed");

	a_badbyte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scan_error == ERR_BYTE |-> token_kind == KIND_EOF && token_length == 16'd1)
		else $error("unrecognised byte token malformed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_kind <= 6'd44)
		else $error("kind out of range");

endmodule

bind source_lexer slex_checker u_slex_checker (
	.clk, .arst_n, .out_valid, .out_stall,
	.token_kind, .token_length, .scan_error, .run_last
);
